### src/framebuffer_pixel_line_rect_engine_unit_assert.svh
// Assertion macros shared by the checker of the fill engine.
// Each expects clk and arst_n in scope; no other dependencies.
`ifndef FRAMEBUFFER_PIXEL_LINE_RECT_ENGINE_UNIT_ASSERT_SVH
`define FRAMEBUFFER_PIXEL_LINE_RECT_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define FPE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FPE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/fpe_pkg.sv
// Shared constants, codes and types of the frame store fill engine.
// No dependencies.
`default_nettype none

package fpe_pkg;

	localparam int FRAME_BYTES = 262144;
	localparam int ADDR_W      = $clog2(FRAME_BYTES);
	localparam int ROW_W       = ADDR_W - 2;
	localparam int BANK_DEPTH  = (FRAME_BYTES + 3) / 4;

	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int PROD_W  = 25;
	localparam int IDX_W   = 26;
	localparam int BASE_W  = 28;
	localparam int LEN_W   = 15;
	localparam int END_W   = 29;
	localparam int COLOR_W = 32;
	localparam int NB_W    = 3;

	localparam logic [END_W-1:0] FRAME_END = END_W'(FRAME_BYTES);

	localparam logic [2:0] CMD_WRITE = 3'd0;
	localparam logic [2:0] CMD_READ  = 3'd1;
	localparam logic [2:0] CMD_HLINE = 3'd2;
	localparam logic [2:0] CMD_VLINE = 3'd3;
	localparam logic [2:0] CMD_RECT  = 3'd4;

	localparam logic [2:0] FMT_8BPP  = 3'd0;
	localparam logic [2:0] FMT_15BPP = 3'd1;
	localparam logic [2:0] FMT_16BPP = 3'd2;
	localparam logic [2:0] FMT_24BPP = 3'd3;
	localparam logic [2:0] FMT_32BPP = 3'd4;

	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_FORMAT = 2'd2;

	typedef struct packed {
		logic              wr;
		logic              rd;
		logic [ADDR_W-1:0] addr;
		logic [NB_W-1:0]   nb;
		logic [COLOR_W-1:0] color;
	} store_req_t;

	// bytes per pixel; zero for an unknown format
	function automatic logic [NB_W-1:0] bytes_per_px(input logic [2:0] fmt);
		logic [NB_W-1:0] nb;
		unique case (fmt)
			FMT_8BPP:             nb = 3'd1;
			FMT_15BPP, FMT_16BPP: nb = 3'd2;
			FMT_24BPP:            nb = 3'd3;
			FMT_32BPP:            nb = 3'd4;
			default:              nb = 3'd0;
		endcase
		return nb;
	endfunction

endpackage

`default_nettype wire

### src/framebuffer_pixel_line_rect_engine_unit.sv
// Fill engine top level: config registers, row/pixel sequencer, frame store.
// Depends on fpe_pkg and fpe_frame_store.
//
//  channel   | ports                                              | handshake
//  ----------+----------------------------------------------------+-------------------
//  command   | cmd x_left y_top x_right y_bottom color_value      | start && !busy
//  result    | status read_color                                  | done, one cycle
//  config    | cfg_index cfg_data                                 | cfg_valid&cfg_ready
//
// One command at a time; busy is high from acceptance until the done cycle.
// Busy steps: the checks, then per row the address setup (multiply, scale, store
// bound) and one pixel written per cycle, then a closing row check; a row with no
// pixels or an unknown format gets only its row check. A read ends instead with the
// store's registered read and the capture of its data. Config is taken only when idle.
// Reset clears control state and the config registers; store contents are
// undefined until written. The result receiver cannot stall.
`default_nettype none

module framebuffer_pixel_line_rect_engine_unit (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [2:0]                      cmd,
	input  wire logic [fpe_pkg::COORD_W-1:0]     x_left,
	input  wire logic [fpe_pkg::COORD_W-1:0]     y_top,
	input  wire logic [fpe_pkg::COORD_W-1:0]     x_right,
	input  wire logic [fpe_pkg::COORD_W-1:0]     y_bottom,
	input  wire logic [fpe_pkg::COLOR_W-1:0]     color_value,
	output logic                                 done,
	output logic                                 status,
	output logic      [fpe_pkg::COLOR_W-1:0]     read_color,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [fpe_pkg::REG_IDX_W-1:0]   cfg_index,
	input  wire logic [fpe_pkg::DIM_W-1:0]       cfg_data
);
	import fpe_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ROW,
		ST_BASE,
		ST_FIT,
		ST_FILL,
		ST_READ,
		ST_RDWAIT
	} state_t;

	state_t state_q;

	logic [DIM_W-1:0] width_q, height_q;
	logic [2:0]       format_q;

	logic [2:0]         cmd_q;
	logic [COORD_W-1:0] xl_q, yt_q, xr_q, yb_q, yend_q;
	logic [COLOR_W-1:0] color_q;
	logic [DIM_W-1:0]   y_q, span_q, cnt_q;
	logic               empty_q;
	logic [PROD_W-1:0]  prod_q;
	logic [LEN_W-1:0]   len_q;
	logic [BASE_W-1:0]  base_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               done_q, status_q;
	logic [COLOR_W-1:0] read_color_q;

	logic [NB_W-1:0]    nb;
	logic               is_px, is_h, is_v, is_r, fail_c;
	logic [COORD_W-1:0] xend_c, yend_c;
	logic [IDX_W-1:0]   idx_c;
	logic [BASE_W-1:0]  idx2_c, base_c;
	logic [END_W-1:0]   end_c;
	store_req_t         req;
	logic [COLOR_W-1:0] store_rd;

	assign cfg_ready = (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign read_color = read_color_q;
	assign nb        = bytes_per_px(format_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			height_q <= '0;
			format_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				REG_FORMAT: format_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// coordinate checks per command
	always_comb begin
		logic xl_off, xr_off, yt_off, yb_off;
		xl_off = {1'b0, xl_q} >= width_q;
		xr_off = {1'b0, xr_q} >= width_q;
		yt_off = {1'b0, yt_q} >= height_q;
		yb_off = {1'b0, yb_q} >= height_q;
		is_px  = (cmd_q == CMD_WRITE) || (cmd_q == CMD_READ);
		is_h   = (cmd_q == CMD_HLINE);
		is_v   = (cmd_q == CMD_VLINE);
		is_r   = (cmd_q == CMD_RECT);
		fail_c = (is_px && (xl_off || yt_off)) ||
			(is_h && (xl_off || xr_off || yt_off)) ||
			(is_v && (xl_off || yt_off || yb_off)) ||
			(is_r && (xl_off || xr_off || yt_off));
		xend_c = (is_h || is_r) ? xr_q : xl_q;
		yend_c = (is_v || is_r) ? yb_q : yt_q;
	end

	// pixel index, byte address and end of row span
	always_comb begin
		idx_c  = {1'b0, prod_q} + {{(IDX_W-COORD_W){1'b0}}, xl_q};
		idx2_c = {2'b00, idx_c};
		case (nb)
			3'd2:    base_c = idx2_c << 1;
			3'd3:    base_c = (idx2_c << 1) + idx2_c;
			3'd4:    base_c = idx2_c << 2;
			default: base_c = idx2_c;
		endcase
		end_c = {1'b0, base_q} + {{(END_W-LEN_W){1'b0}}, len_q};
	end

	always_comb begin
		req.wr    = (state_q == ST_FILL);
		req.rd    = (state_q == ST_READ);
		req.addr  = addr_q;
		req.nb    = nb;
		req.color = color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			status_q     <= 1'b0;
			read_color_q <= '0;
			cmd_q        <= '0;
			xl_q         <= '0;
			yt_q         <= '0;
			xr_q         <= '0;
			yb_q         <= '0;
			yend_q       <= '0;
			color_q      <= '0;
			y_q          <= '0;
			span_q       <= '0;
			cnt_q        <= '0;
			empty_q      <= 1'b0;
			prod_q       <= '0;
			len_q        <= '0;
			base_q       <= '0;
			addr_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						xl_q    <= x_left;
						yt_q    <= y_top;
						xr_q    <= x_right;
						yb_q    <= y_bottom;
						color_q <= color_value;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (fail_c || !(is_px || is_h || is_v || is_r)) begin
						done_q       <= 1'b1;
						status_q     <= fail_c;
						read_color_q <= '0;
						state_q      <= ST_IDLE;
					end else begin
						yend_q  <= yend_c;
						y_q     <= {1'b0, yt_q};
						span_q  <= {1'b0, xend_c} - {1'b0, xl_q} + DIM_W'(1);
						empty_q <= xend_c < xl_q;
						state_q <= ST_ROW;
					end
				end
				ST_ROW: begin
					if (y_q > {1'b0, yend_q}) begin
						done_q       <= 1'b1;
						status_q     <= 1'b0;
						read_color_q <= '0;
						state_q      <= ST_IDLE;
					end else if (y_q >= height_q) begin
						done_q       <= 1'b1;
						status_q     <= 1'b1;
						read_color_q <= '0;
						state_q      <= ST_IDLE;
					end else if (empty_q || nb == '0) begin
						y_q <= y_q + DIM_W'(1);
					end else begin
						prod_q  <= {{(PROD_W-DIM_W){1'b0}}, width_q} *
							{{(PROD_W-COORD_W){1'b0}}, y_q[COORD_W-1:0]};
						len_q   <= {2'b00, span_q} * {{(LEN_W-NB_W){1'b0}}, nb};
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					base_q  <= base_c;
					state_q <= ST_FIT;
				end
				ST_FIT: begin
					if (end_c > FRAME_END) begin
						done_q       <= 1'b1;
						status_q     <= 1'b1;
						read_color_q <= '0;
						state_q      <= ST_IDLE;
					end else begin
						addr_q  <= base_q[ADDR_W-1:0];
						cnt_q   <= span_q;
						state_q <= (cmd_q == CMD_READ) ? ST_READ : ST_FILL;
					end
				end
				ST_FILL: begin
					addr_q <= addr_q + ADDR_W'(nb);
					cnt_q  <= cnt_q - DIM_W'(1);
					if (cnt_q == DIM_W'(1)) begin
						y_q     <= y_q + DIM_W'(1);
						state_q <= ST_ROW;
					end
				end
				ST_READ: begin
					state_q <= ST_RDWAIT;
				end
				ST_RDWAIT: begin
					done_q       <= 1'b1;
					status_q     <= 1'b0;
					read_color_q <= store_rd;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	fpe_frame_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (store_rd)
	);

endmodule

`default_nettype wire

### src/fpe_byte_ram.sv
// Generic single-port byte RAM, registered read data.
// No dependencies.
`default_nettype none

module fpe_byte_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] addr,
	input  wire logic [7:0]    wdata,
	output logic      [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

### src/fpe_frame_store.sv
// Byte-addressed frame store: four byte banks, one pixel per cycle.
// Depends on fpe_pkg and fpe_byte_ram.
`default_nettype none

module fpe_frame_store (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire fpe_pkg::store_req_t   req,
	output logic [fpe_pkg::COLOR_W-1:0] rd_data
);
	import fpe_pkg::*;

	logic [7:0]       bank_rd [4];
	logic [1:0]       off_s1;
	logic [NB_W-1:0]  nb_s1;

	// byte j of the pixel sits in bank (addr + j) mod 4
	for (genvar k = 0; k < 4; k++) begin : g_bank
		logic [1:0]        j;
		logic [ADDR_W-1:0] byte_addr;
		logic              lane_en;
		logic [COLOR_W-1:0] shifted;

		assign j         = 2'(k) - req.addr[1:0];
		assign byte_addr = req.addr + ADDR_W'(j);
		assign lane_en   = {1'b0, j} < req.nb;
		assign shifted   = req.color >> {j, 3'b000};

		fpe_byte_ram #(
			.DEPTH (BANK_DEPTH),
			.AW    (ROW_W)
		) u_bank (
			.clk   (clk),
			.we    (req.wr && lane_en),
			.addr  (byte_addr[ADDR_W-1:2]),
			.wdata (shifted[7:0]),
			.rdata (bank_rd[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_s1 <= '0;
			nb_s1  <= '0;
		end else if (req.rd) begin
			off_s1 <= req.addr[1:0];
			nb_s1  <= req.nb;
		end
	end

	always_comb begin
		rd_data = '0;
		for (int j = 0; j < 4; j++) begin
			if (NB_W'(j) < nb_s1) begin
				rd_data[8*j +: 8] = bank_rd[2'(off_s1 + 2'(j))];
			end
		end
	end

endmodule

`default_nettype wire

### src/fpe_checker.sv
// Port-level checker for the fill engine, bound to the top level.
// Depends on framebuffer_pixel_line_rect_engine_unit_assert.svh.
`default_nettype none

`include "framebuffer_pixel_line_rect_engine_unit_assert.svh"

module fpe_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	`FPE_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted command did not raise busy")
	`FPE_ASSERT_NOW(a_done_idle, done, !busy, "result strobe while still busy")
	`FPE_ASSERT_NEXT(a_busy_ends_done, busy, busy || done, "busy dropped without a result")
	`FPE_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule

bind framebuffer_pixel_line_rect_engine_unit fpe_checker u_fpe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
